>>> rtl/core/lvn_pkg.sv
// Shared types, constants and datapath command codes for local value numbering.
`timescale 1ns / 1ps

package lvn_pkg;

  localparam int NUM_REGS_DEF      = 256;
  localparam int CONST_ENTRIES_DEF = 64;
  localparam int EXPR_ENTRIES_DEF  = 64;
  localparam int MAX_VALUES_DEF    = 1024;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SUB    = 2'd1;
  localparam logic [1:0] OP_MOV    = 2'd2;
  localparam logic [1:0] OP_OPAQUE = 2'd3;

  localparam logic [3:0] UOP_NONE  = 4'd0;
  localparam logic [3:0] UOP_LOAD  = 4'd1;
  localparam logic [3:0] UOP_OVF   = 4'd2;
  localparam logic [3:0] UOP_IDX0  = 4'd3;
  localparam logic [3:0] UOP_INC   = 4'd4;
  localparam logic [3:0] UOP_CHIT  = 4'd5;
  localparam logic [3:0] UOP_CNEW  = 4'd6;
  localparam logic [3:0] UOP_RGET  = 4'd7;
  localparam logic [3:0] UOP_CPN   = 4'd8;
  localparam logic [3:0] UOP_EHIT  = 4'd9;
  localparam logic [3:0] UOP_HLAT  = 4'd10;
  localparam logic [3:0] UOP_HCHK  = 4'd11;
  localparam logic [3:0] UOP_TAKEE = 4'd12;
  localparam logic [3:0] UOP_TAKE  = 4'd13;
  localparam logic [3:0] UOP_BIND  = 4'd14;
  localparam logic [3:0] UOP_EMIT  = 4'd15;

  typedef struct packed {
    logic [1:0]         operation;
    logic               first_of_block;
    logic [7:0]         dst_reg;
    logic               src1_is_const;
    logic [7:0]         src1_reg;
    logic signed [31:0] src1_const;
    logic               src2_is_const;
    logic [7:0]         src2_reg;
    logic signed [31:0] src2_const;
  } item_t;

  typedef struct packed {
    logic [1:0]         out_operation;
    logic [7:0]         out_dst_reg;
    logic               out_src1_is_const;
    logic [7:0]         out_src1_reg;
    logic signed [31:0] out_src1_const;
    logic               out_src2_is_const;
    logic [7:0]         out_src2_reg;
    logic signed [31:0] out_src2_const;
    logic               replaced;
    logic [9:0]         value_number;
    logic               table_full;
  } result_t;

  typedef struct packed {
    logic [3:0] uop;
    logic       side;
    logic       rsel_h;
    logic       zero;
    logic       repl;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic       bad;
    logic [1:0] op;
    logic       c1;
    logic       cur_const;
    logic       cend;
    logic       chit;
    logic       eend;
    logic       ehit;
    logic       hv;
    logic       ovf;
    logic       out_busy;
  } stat_t;

endpackage

>>> rtl/core/lvn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lvn_ctrl.sv
// Sequencing state machine that steps the datapath through one instruction.
`timescale 1ns / 1ps

module lvn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  lvn_pkg::stat_t stat,
  output lvn_pkg::cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_OPND  = 5'd2;
  localparam logic [4:0] S_CRD   = 5'd3;
  localparam logic [4:0] S_CCMP  = 5'd4;
  localparam logic [4:0] S_RRD   = 5'd5;
  localparam logic [4:0] S_RGET  = 5'd6;
  localparam logic [4:0] S_CPN   = 5'd7;
  localparam logic [4:0] S_EXPR0 = 5'd8;
  localparam logic [4:0] S_ERD   = 5'd9;
  localparam logic [4:0] S_ECMP  = 5'd10;
  localparam logic [4:0] S_HRD   = 5'd11;
  localparam logic [4:0] S_HLAT  = 5'd12;
  localparam logic [4:0] S_HRRD  = 5'd13;
  localparam logic [4:0] S_HCHK  = 5'd14;
  localparam logic [4:0] S_TAKEE = 5'd15;
  localparam logic [4:0] S_TAKE  = 5'd16;
  localparam logic [4:0] S_BIND  = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;

  logic [4:0] state, state_next;
  logic       side, side_next;
  logic       zero, zero_next;
  logic       repl, repl_next;
  logic [4:0] after_opnd;
  logic       after_side;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    after_opnd = S_OPND;
    after_side = side;
    if (stat.op == lvn_pkg::OP_MOV) begin
      after_opnd = S_CPN;
    end else if (side) begin
      after_opnd = S_EXPR0;
    end else begin
      after_side = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    side_next  = side;
    zero_next  = zero;
    repl_next  = repl;
    cmd        = '0;
    cmd.side   = side;
    cmd.zero   = zero;
    cmd.repl   = repl;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.uop    = lvn_pkg::UOP_LOAD;
          side_next  = 1'b0;
          zero_next  = 1'b0;
          repl_next  = 1'b0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.full) begin
          zero_next  = 1'b1;
          state_next = S_EMIT;
        end else if (stat.bad) begin
          cmd.uop    = lvn_pkg::UOP_OVF;
          zero_next  = 1'b1;
          state_next = S_EMIT;
        end else if (stat.op != lvn_pkg::OP_MOV && stat.op != lvn_pkg::OP_OPAQUE) begin
          state_next = S_OPND;
        end else if (stat.op == lvn_pkg::OP_MOV && !stat.c1) begin
          state_next = S_OPND;
        end else begin
          state_next = S_TAKE;
        end
      end
      S_OPND: begin
        cmd.uop    = lvn_pkg::UOP_IDX0;
        state_next = stat.cur_const ? S_CRD : S_RRD;
      end
      S_CRD: begin
        state_next = S_CCMP;
      end
      S_CCMP: begin
        if (stat.cend) begin
          cmd.uop = lvn_pkg::UOP_CNEW;
          if (stat.ovf) begin
            zero_next  = 1'b1;
            state_next = S_EMIT;
          end else begin
            side_next  = after_side;
            state_next = after_opnd;
          end
        end else if (stat.chit) begin
          cmd.uop    = lvn_pkg::UOP_CHIT;
          side_next  = after_side;
          state_next = after_opnd;
        end else begin
          cmd.uop    = lvn_pkg::UOP_INC;
          state_next = S_CRD;
        end
      end
      S_RRD: begin
        state_next = S_RGET;
      end
      S_RGET: begin
        cmd.uop = lvn_pkg::UOP_RGET;
        if (stat.ovf) begin
          zero_next  = 1'b1;
          state_next = S_EMIT;
        end else begin
          side_next  = after_side;
          state_next = after_opnd;
        end
      end
      S_CPN: begin
        cmd.uop    = lvn_pkg::UOP_CPN;
        state_next = S_BIND;
      end
      S_EXPR0: begin
        cmd.uop    = lvn_pkg::UOP_IDX0;
        state_next = S_ERD;
      end
      S_ERD: begin
        state_next = S_ECMP;
      end
      S_ECMP: begin
        if (stat.eend) begin
          state_next = S_TAKEE;
        end else if (stat.ehit) begin
          cmd.uop    = lvn_pkg::UOP_EHIT;
          state_next = S_HRD;
        end else begin
          cmd.uop    = lvn_pkg::UOP_INC;
          state_next = S_ERD;
        end
      end
      S_HRD: begin
        state_next = S_HLAT;
      end
      S_HLAT: begin
        cmd.uop    = lvn_pkg::UOP_HLAT;
        state_next = S_HRRD;
      end
      S_HRRD: begin
        cmd.rsel_h = 1'b1;
        state_next = S_HCHK;
      end
      S_HCHK: begin
        cmd.uop    = lvn_pkg::UOP_HCHK;
        cmd.rsel_h = 1'b1;
        if (stat.hv) begin
          repl_next  = 1'b1;
          state_next = S_BIND;
        end else begin
          state_next = S_TAKEE;
        end
      end
      S_TAKEE: begin
        cmd.uop = lvn_pkg::UOP_TAKEE;
        if (stat.ovf) begin
          zero_next  = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_BIND;
        end
      end
      S_TAKE: begin
        cmd.uop = lvn_pkg::UOP_TAKE;
        if (stat.ovf) begin
          zero_next  = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_BIND;
        end
      end
      S_BIND: begin
        cmd.uop    = lvn_pkg::UOP_BIND;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.uop    = lvn_pkg::UOP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= 1'b0;
      zero  <= 1'b0;
      repl  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
      zero  <= zero_next;
      repl  <= repl_next;
    end
  end

endmodule

>>> rtl/core/lvn_dp.sv
// Datapath: number tables, counters, working registers and result register.
`timescale 1ns / 1ps

module lvn_dp #(
  parameter int NUM_REGS      = lvn_pkg::NUM_REGS_DEF,
  parameter int CONST_ENTRIES = lvn_pkg::CONST_ENTRIES_DEF,
  parameter int EXPR_ENTRIES  = lvn_pkg::EXPR_ENTRIES_DEF,
  parameter int MAX_VALUES    = lvn_pkg::MAX_VALUES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lvn_pkg::item_t   item,
  input  lvn_pkg::cmd_t    cmd,
  output lvn_pkg::stat_t   stat,
  input  logic             result_stall,
  output logic             result_valid,
  output lvn_pkg::result_t result
);

  localparam int REG_W = $clog2(NUM_REGS);
  localparam int VN_W  = $clog2(MAX_VALUES);
  localparam int NN_W  = $clog2(MAX_VALUES + 1);
  localparam int CA_W  = (CONST_ENTRIES > 1) ? $clog2(CONST_ENTRIES) : 1;
  localparam int EA_W  = (EXPR_ENTRIES > 1) ? $clog2(EXPR_ENTRIES) : 1;
  localparam int CC_W  = $clog2(CONST_ENTRIES + 1);
  localparam int EC_W  = $clog2(EXPR_ENTRIES + 1);
  localparam int MAXE  = (CONST_ENTRIES > EXPR_ENTRIES) ? CONST_ENTRIES : EXPR_ENTRIES;
  localparam int IDX_W = $clog2(MAXE + 1);
  localparam int EK_W  = 1 + 2 * VN_W;

  lvn_pkg::item_t   q;
  lvn_pkg::result_t out_next;
  logic [IDX_W-1:0] idx;
  logic [VN_W-1:0]  l, r, n, en;
  logic [REG_W-1:0] h;
  logic             found;
  logic [CC_W-1:0]  ccount;
  logic [EC_W-1:0]  ecount;
  logic [NN_W-1:0]  next_number;
  logic             full;
  logic [NUM_REGS-1:0] reg_valid;

  logic             cur_c;
  logic [31:0]      cur_k;
  logic [REG_W-1:0] cur_ra, dst_ra;
  logic [VN_W-1:0]  fresh;
  logic             nums_out;
  logic [EK_W-1:0]  ekey;
  logic             two;

  logic [32+VN_W-1:0]   c_rd, c_wd;
  logic [EK_W+VN_W-1:0] e_rd, e_wd;
  logic [VN_W-1:0]      r_rd, r_wd;
  logic [REG_W-1:0]     h_rd, h_wd, r_raddr, r_waddr;
  logic [VN_W-1:0]      h_waddr;
  logic [EA_W-1:0]      e_waddr;
  logic                 c_we, e_we, r_we, h_we, bind_en, rget_new;

  assign cur_c    = cmd.side ? q.src2_is_const : q.src1_is_const;
  assign cur_k    = cmd.side ? q.src2_const : q.src1_const;
  assign cur_ra   = REG_W'(cmd.side ? q.src2_reg : q.src1_reg);
  assign dst_ra   = REG_W'(q.dst_reg);
  assign fresh    = VN_W'(next_number);
  assign nums_out = (next_number >= NN_W'(MAX_VALUES));
  assign ekey     = {q.operation[0], l, r};

  always_comb begin
    stat.full      = full;
    stat.bad       = (32'(q.dst_reg) >= NUM_REGS)
                     || (q.operation != lvn_pkg::OP_OPAQUE && !q.src1_is_const
                         && 32'(q.src1_reg) >= NUM_REGS)
                     || ((q.operation == lvn_pkg::OP_ADD || q.operation == lvn_pkg::OP_SUB)
                         && !q.src2_is_const && 32'(q.src2_reg) >= NUM_REGS);
    stat.op        = q.operation;
    stat.c1        = q.src1_is_const;
    stat.cur_const = cur_c;
    stat.cend      = (idx >= IDX_W'(ccount));
    stat.chit      = (c_rd[VN_W +: 32] == cur_k);
    stat.eend      = (idx >= IDX_W'(ecount));
    stat.ehit      = (e_rd[VN_W +: EK_W] == ekey);
    stat.hv        = reg_valid[h] && (r_rd == en);
    stat.out_busy  = result_valid && result_stall;
    case (cmd.uop)
      lvn_pkg::UOP_CNEW:  stat.ovf = (ccount >= CC_W'(CONST_ENTRIES)) || nums_out;
      lvn_pkg::UOP_RGET:  stat.ovf = !reg_valid[cur_ra] && nums_out;
      lvn_pkg::UOP_TAKEE: stat.ovf = nums_out || (!found && ecount >= EC_W'(EXPR_ENTRIES));
      lvn_pkg::UOP_TAKE:  stat.ovf = nums_out;
      default:            stat.ovf = 1'b0;
    endcase
  end

  assign bind_en  = (cmd.uop == lvn_pkg::UOP_BIND);
  assign rget_new = (cmd.uop == lvn_pkg::UOP_RGET) && !reg_valid[cur_ra] && !nums_out;
  assign c_we     = (cmd.uop == lvn_pkg::UOP_CNEW) && !stat.ovf;
  assign c_wd     = {cur_k, fresh};
  assign e_we     = (cmd.uop == lvn_pkg::UOP_TAKEE) && !stat.ovf;
  assign e_waddr  = found ? idx[EA_W-1:0] : ecount[EA_W-1:0];
  assign e_wd     = {ekey, fresh};
  assign r_we     = rget_new || bind_en;
  assign r_waddr  = bind_en ? dst_ra : cur_ra;
  assign r_wd     = bind_en ? n : fresh;
  assign r_raddr  = cmd.rsel_h ? h : cur_ra;
  assign h_we     = r_we;
  assign h_waddr  = bind_en ? n : fresh;
  assign h_wd     = bind_en ? dst_ra : cur_ra;

  lvn_ram #(.WIDTH(32 + VN_W), .DEPTH(CONST_ENTRIES)) u_const (
    .clk(clk), .we(c_we), .waddr(ccount[CA_W-1:0]), .wdata(c_wd),
    .raddr(idx[CA_W-1:0]), .rdata(c_rd)
  );

  lvn_ram #(.WIDTH(EK_W + VN_W), .DEPTH(EXPR_ENTRIES)) u_expr (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wd),
    .raddr(idx[EA_W-1:0]), .rdata(e_rd)
  );

  lvn_ram #(.WIDTH(VN_W), .DEPTH(NUM_REGS)) u_regnum (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wd),
    .raddr(r_raddr), .rdata(r_rd)
  );

  lvn_ram #(.WIDTH(REG_W), .DEPTH(MAX_VALUES)) u_holder (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wd),
    .raddr(en), .rdata(h_rd)
  );

  // The emitted request: the instruction as given, or a copy from the holder.
  always_comb begin
    two      = (q.operation != lvn_pkg::OP_MOV);
    out_next = '0;
    out_next.out_operation     = q.operation;
    out_next.out_dst_reg       = q.dst_reg;
    out_next.out_src1_is_const = q.src1_is_const;
    out_next.out_src1_reg      = q.src1_is_const ? 8'd0 : q.src1_reg;
    out_next.out_src1_const    = q.src1_is_const ? q.src1_const : 32'sd0;
    out_next.out_src2_is_const = two && q.src2_is_const;
    out_next.out_src2_reg      = (two && !q.src2_is_const) ? q.src2_reg : 8'd0;
    out_next.out_src2_const    = (two && q.src2_is_const) ? q.src2_const : 32'sd0;
    out_next.value_number      = cmd.zero ? 10'd0 : 10'(n);
    out_next.table_full        = full;
    if (cmd.repl) begin
      out_next                = '0;
      out_next.out_operation  = lvn_pkg::OP_MOV;
      out_next.out_dst_reg    = q.dst_reg;
      out_next.out_src1_reg   = 8'(h);
      out_next.replaced       = 1'b1;
      out_next.value_number   = 10'(n);
      out_next.table_full     = full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ccount       <= '0;
      ecount       <= '0;
      next_number  <= '0;
      full         <= 1'b0;
      reg_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && cmd.uop != lvn_pkg::UOP_EMIT) begin
        result_valid <= 1'b0;
      end
      case (cmd.uop)
        lvn_pkg::UOP_LOAD: begin
          if (item.first_of_block) begin
            ccount      <= '0;
            ecount      <= '0;
            next_number <= '0;
            full        <= 1'b0;
            reg_valid   <= '0;
          end
        end
        lvn_pkg::UOP_OVF: begin
          full <= 1'b1;
        end
        lvn_pkg::UOP_CNEW: begin
          if (stat.ovf) begin
            full <= 1'b1;
          end else begin
            ccount      <= ccount + 1'b1;
            next_number <= next_number + 1'b1;
          end
        end
        lvn_pkg::UOP_RGET: begin
          if (stat.ovf) begin
            full <= 1'b1;
          end else if (!reg_valid[cur_ra]) begin
            reg_valid[cur_ra] <= 1'b1;
            next_number       <= next_number + 1'b1;
          end
        end
        lvn_pkg::UOP_TAKEE: begin
          if (!nums_out) begin
            next_number <= next_number + 1'b1;
          end
          if (stat.ovf) begin
            full <= 1'b1;
          end else if (!found) begin
            ecount <= ecount + 1'b1;
          end
        end
        lvn_pkg::UOP_TAKE: begin
          if (stat.ovf) begin
            full <= 1'b1;
          end else begin
            next_number <= next_number + 1'b1;
          end
        end
        lvn_pkg::UOP_BIND: begin
          reg_valid[dst_ra] <= 1'b1;
        end
        lvn_pkg::UOP_EMIT: begin
          result_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.uop)
      lvn_pkg::UOP_LOAD: begin
        q   <= item;
        idx <= '0;
      end
      lvn_pkg::UOP_IDX0: begin
        idx   <= '0;
        found <= 1'b0;
      end
      lvn_pkg::UOP_INC: begin
        idx <= idx + 1'b1;
      end
      lvn_pkg::UOP_CHIT: begin
        if (cmd.side) begin
          r <= c_rd[VN_W-1:0];
        end else begin
          l <= c_rd[VN_W-1:0];
        end
      end
      lvn_pkg::UOP_CNEW: begin
        if (cmd.side) begin
          r <= fresh;
        end else begin
          l <= fresh;
        end
      end
      lvn_pkg::UOP_RGET: begin
        if (cmd.side) begin
          r <= reg_valid[cur_ra] ? r_rd : fresh;
        end else begin
          l <= reg_valid[cur_ra] ? r_rd : fresh;
        end
      end
      lvn_pkg::UOP_CPN: begin
        n <= l;
      end
      lvn_pkg::UOP_EHIT: begin
        en    <= e_rd[VN_W-1:0];
        found <= 1'b1;
      end
      lvn_pkg::UOP_HLAT: begin
        h <= h_rd;
      end
      lvn_pkg::UOP_HCHK: begin
        n <= en;
      end
      lvn_pkg::UOP_TAKEE: begin
        n <= fresh;
      end
      lvn_pkg::UOP_TAKE: begin
        n <= fresh;
      end
      lvn_pkg::UOP_EMIT: begin
        result <= out_next;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/local_value_numbering.sv
// Top level of the local value numbering block.
`timescale 1ns / 1ps

// Takes one add, sub, mov or opaque request at a time and returns one result request for it.
// A request is worked through a sequence of table lookups in single-write, single-read
// RAMs; the constant and expression tables are searched linearly, entry by entry, and a
// search that misses also probes the slot past the last entry. A finished result sits in
// an output register, so the next request is accepted while it waits. A first_of_block
// request clears all tables at once.
module local_value_numbering #(
  parameter int NUM_REGS      = lvn_pkg::NUM_REGS_DEF,
  parameter int CONST_ENTRIES = lvn_pkg::CONST_ENTRIES_DEF,
  parameter int EXPR_ENTRIES  = lvn_pkg::EXPR_ENTRIES_DEF,
  parameter int MAX_VALUES    = lvn_pkg::MAX_VALUES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  lvn_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output lvn_pkg::result_t result
);

  lvn_pkg::cmd_t  cmd;
  lvn_pkg::stat_t stat;

  lvn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .stat(stat), .cmd(cmd)
  );

  lvn_dp #(
    .NUM_REGS(NUM_REGS), .CONST_ENTRIES(CONST_ENTRIES),
    .EXPR_ENTRIES(EXPR_ENTRIES), .MAX_VALUES(MAX_VALUES)
  ) u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .stat(stat),
    .result_stall(result_stall), .result_valid(result_valid), .result(result)
  );

endmodule
